// File: rtl/u8u32_pkg.sv
`timescale 1ns / 1ps

package u8u32_pkg;

	// Common widths of the decoder datapath.
	localparam int CP_W    = 21;
	localparam int COUNT_W = 16;

	typedef logic [CP_W-1:0]    cp_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [7:0]         byte_t;

	// Substitute for any invalid sequence.
	localparam cp_t REPL_CHAR = 21'h00FFFD;

	// Sequence length codes.
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_TWO  = 3'd2;
	localparam logic [2:0] SEQ_THREE = 3'd3;
	localparam logic [2:0] SEQ_FOUR = 3'd4;

	// End reason codes.
	localparam logic END_ZERO_BYTE = 1'b0;
	localparam logic END_CAPACITY  = 1'b1;

	// Reset value of the capacity register.
	localparam count_t CAP_RESET = 16'hFFFF;

	// Checks a completed multi-byte value against the shortest form, the
	// surrogate range and the upper end of the code space.
	function automatic logic value_ok(input cp_t v, input logic [2:0] len);
		logic ok;
		begin
			ok = 1'b0;
			case (len)
				SEQ_TWO:   ok = (v >= 21'h000080);
				SEQ_THREE: ok = (v >= 21'h000800) && ((v < 21'h00D800) || (v > 21'h00DFFF));
				SEQ_FOUR:  ok = (v >= 21'h010000) && (v <= 21'h10FFFF);
				default:   ok = 1'b0;
			endcase
			return ok;
		end
	endfunction

endpackage

// File: rtl/utf8_to_utf32_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-32 stream decoder with U+FFFD replacement.
// A code point passes from its last accepted byte through the input register, one decode
// step and the result register to the outputs.
// Throughput: one byte per cycle; a stalled output lets one more byte in, then holds.
// Reset (arst_n low) clears all valid flags and the sequence state and sets
// the output capacity to 65535.
module utf8_to_utf32_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write channel.
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  u8u32_pkg::count_t   cfg_data,
	// Byte input channel.
	input  logic                in_valid,
	output logic                in_ready,
	input  u8u32_pkg::byte_t    in_byte,
	input  logic                first_of_string,
	// Code point output channel.
	output logic                out_valid,
	input  logic                out_ready,
	output u8u32_pkg::cp_t      code_point,
	output logic                is_replacement,
	output logic                is_last,
	output logic                end_reason,
	output u8u32_pkg::count_t   emitted_count
);
	import u8u32_pkg::*;

	// Configuration and decoder state.
	count_t     capacity_q;
	cp_t        partial_q;
	logic [1:0] trail_q;
	logic [2:0] seq_len_q;
	count_t     count_q;
	logic       done_q;

	// Input stage.
	logic       valid_s1;
	byte_t      byte_s1;
	logic       first_s1;

	// Result stage.
	logic       valid_s2;
	cp_t        cp_s2;
	logic       repl_s2;
	logic       last_s2;
	logic       reason_s2;
	count_t     count_s2;

	// Decode step outputs.
	logic       advance;
	logic       emit;
	cp_t        emit_cp;
	logic       emit_repl;
	logic       emit_zero;
	logic       emit_last;
	logic       emit_reason;
	count_t     next_count;
	cp_t        next_partial;
	logic [1:0] next_trail;
	logic [2:0] next_seq_len;
	logic       next_done;

	// Working values inside the decode step.
	cp_t        cur_partial;
	logic [1:0] cur_trail;
	logic [2:0] cur_seq_len;
	count_t     cur_count;
	logic       cur_done;
	cp_t        shifted;
	count_t     cap_eff;
	count_t     count_inc;

	// Stage 1 moves on whenever the result register is free or being drained.
	assign advance   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Decode one byte against the current sequence state.
	always_comb begin
		cur_partial = partial_q;
		cur_trail   = trail_q;
		cur_seq_len = seq_len_q;
		cur_count   = count_q;
		cur_done    = done_q;
		if (first_s1) begin
			cur_partial = '0;
			cur_trail   = '0;
			cur_seq_len = SEQ_NONE;
			cur_count   = '0;
			cur_done    = 1'b0;
		end

		emit         = 1'b0;
		emit_cp      = REPL_CHAR;
		emit_repl    = 1'b0;
		emit_zero    = 1'b0;
		next_partial = cur_partial;
		next_trail   = cur_trail;
		next_seq_len = cur_seq_len;
		shifted      = {cur_partial[CP_W-7:0], byte_s1[5:0]};

		if (cur_done) begin
			// String has ended: the byte is dropped.
			emit = 1'b0;
		end else if (cur_trail != 2'd0) begin
			if (byte_s1[7:6] != 2'b10) begin
				// Broken sequence: the offending byte is consumed.
				emit         = 1'b1;
				emit_repl    = 1'b1;
				next_partial = '0;
				next_trail   = '0;
				next_seq_len = SEQ_NONE;
			end else if (cur_trail == 2'd1) begin
				// Last trail byte completes the sequence.
				emit         = 1'b1;
				emit_repl    = !value_ok(shifted, cur_seq_len);
				emit_cp      = emit_repl ? REPL_CHAR : shifted;
				next_partial = '0;
				next_trail   = '0;
				next_seq_len = SEQ_NONE;
			end else begin
				next_partial = shifted;
				next_trail   = cur_trail - 2'd1;
			end
		end else if (!byte_s1[7]) begin
			// ASCII goes straight out; a zero byte ends the string.
			emit      = 1'b1;
			emit_cp   = {13'd0, byte_s1};
			emit_zero = (byte_s1 == 8'h00);
		end else if (byte_s1[7:5] == 3'b110) begin
			next_partial = {16'd0, byte_s1[4:0]};
			next_trail   = 2'd1;
			next_seq_len = SEQ_TWO;
		end else if (byte_s1[7:4] == 4'b1110) begin
			next_partial = {17'd0, byte_s1[3:0]};
			next_trail   = 2'd2;
			next_seq_len = SEQ_THREE;
		end else if (byte_s1[7:3] == 5'b11110) begin
			next_partial = {18'd0, byte_s1[2:0]};
			next_trail   = 2'd3;
			next_seq_len = SEQ_FOUR;
		end else begin
			// Stray trail byte or invalid lead byte.
			emit      = 1'b1;
			emit_repl = 1'b1;
		end

		// Count the emitted code point and check for the end of the string.
		cap_eff     = (capacity_q == '0) ? count_t'(1) : capacity_q;
		count_inc   = cur_count + count_t'(1);
		emit_last   = emit && (emit_zero || (count_inc >= cap_eff));
		emit_reason = emit_zero ? END_ZERO_BYTE : END_CAPACITY;
		next_count  = emit ? count_inc : cur_count;
		next_done   = cur_done || emit_last;
		if (emit_last) begin
			next_partial = '0;
			next_trail   = '0;
			next_seq_len = SEQ_NONE;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// Input register: takes a byte on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= in_byte;
			first_s1 <= first_of_string;
		end
	end

	// Sequence state, updated as each byte leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			trail_q   <= '0;
			seq_len_q <= SEQ_NONE;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else if (valid_s1 && advance) begin
			partial_q <= next_partial;
			trail_q   <= next_trail;
			seq_len_q <= next_seq_len;
			count_q   <= next_count;
			done_q    <= next_done;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && emit) begin
			cp_s2     <= emit_cp;
			repl_s2   <= emit_repl;
			last_s2   <= emit_last;
			reason_s2 <= emit_last ? emit_reason : END_ZERO_BYTE;
			count_s2  <= next_count;
		end
	end

	assign out_valid      = valid_s2;
	assign code_point     = cp_s2;
	assign is_replacement = repl_s2;
	assign is_last        = last_s2;
	assign end_reason     = reason_s2;
	assign emitted_count  = count_s2;

endmodule
